>>> hw/rtl/hv_pump_burst_sequencer_assert.svh
// assertion macros of the pump burst sequencer state machine (hvpbs_seq)
`ifndef HV_PUMP_BURST_SEQUENCER_ASSERT_SVH
`define HV_PUMP_BURST_SEQUENCER_ASSERT_SVH

`ifndef SYNTH

// property that must hold on every clock edge out of reset
`define HVPBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define HVPBS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`else

`define HVPBS_ASSERT(lbl, clk, rstn, prop, msg)
`define HVPBS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

>>> hw/rtl/hvpbs_pkg.sv
// types and constants of the pump burst sequencer
`default_nettype none

package hvpbs_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX     = 2'd3;

    // register reset values
    localparam logic [15:0] DUTY_RESET    = 16'd1600;
    localparam logic [15:0] MEASURE_RESET = 16'd17600;
    localparam logic [9:0]  MAX_RESET     = 10'd300;

    // pump count and result widths
    localparam int COUNT_W = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
    localparam int LEVEL_W = 7;
    localparam int RESULT_BITS = 1 + 1 + 2 + COUNT_W + LEVEL_W;
    localparam int M_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;

    // x / 17 as (x * 7711) >> 17, exact for x below 8721
    localparam int DIV17_MUL   = 7711;
    localparam int DIV17_MUL_W = 13;
    localparam int DIV17_SHIFT = 17;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_PUMP = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] duty_ticks;
        logic [15:0] measure_ticks;
        logic [9:0]  max_pumps;
    } hvpbs_cfg_t;

    // packed lowest bit first in m_tdata: pump_on is bit 0
    typedef struct packed {
        logic [LEVEL_W-1:0] battery_level;
        logic [COUNT_W-1:0] pumps_done;
        phase_t             phase;
        logic               adc_start;
        logic               pump_on;
    } hvpbs_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/hvpbs_cfg_regs.sv
// configuration register bank of the pump burst sequencer
`default_nettype none

module hvpbs_cfg_regs
    import hvpbs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output hvpbs_cfg_t                 cfg
);

    hvpbs_cfg_t cfg_reg;
    hvpbs_cfg_t cfg_next;

    // decode one register write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE:  cfg_next.enable        = cfg_wdata[0];
                REG_DUTY:    cfg_next.duty_ticks    = cfg_wdata[15:0];
                REG_MEASURE: cfg_next.measure_ticks = cfg_wdata[15:0];
                REG_MAX:     cfg_next.max_pumps     = cfg_wdata[9:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.duty_ticks    <= DUTY_RESET;
            cfg_reg.measure_ticks <= MEASURE_RESET;
            cfg_reg.max_pumps     <= MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hvpbs_seq.sv
// burst state machine, pump cycle timer and battery level of the sequencer
`default_nettype none

module hvpbs_seq
    import hvpbs_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int ADC_BITS   = 10
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire logic                period_start,
    input  wire logic                compare_ready,
    input  wire logic                feedback_high,
    input  wire logic                adc_valid,
    input  wire logic [ADC_BITS-1:0] adc_sample,
    input  wire hvpbs_cfg_t          cfg,
    output hvpbs_result_t            result
);

    `include "hv_pump_burst_sequencer_assert.svh"

    localparam int DBL_W  = ADC_BITS + 1;
    localparam int PROD_W = (DBL_W + DIV17_MUL_W > DIV17_SHIFT + LEVEL_W) ?
                            DBL_W + DIV17_MUL_W : DIV17_SHIFT + LEVEL_W;

    phase_t                phase_reg, phase_next;
    logic [COUNT_W-1:0]    pump_count_reg, pump_count_next;
    logic [TIMER_BITS-1:0] cycle_timer_reg, cycle_timer_next;
    logic [ADC_BITS-1:0]   battery_sample_reg, battery_sample_next;

    logic [TIMER_BITS-1:0] duty_cmp;
    logic [TIMER_BITS-1:0] measure_cmp;
    logic [TIMER_BITS-1:0] timer_inc;
    logic                  cycle_end;
    logic [COUNT_W-1:0]    count_sat;
    logic                  adc_start;
    logic [DBL_W-1:0]      sample_dbl;
    logic [PROD_W-1:0]     level_prod;

    // thresholds compared within the timer width
    assign duty_cmp    = TIMER_BITS'(cfg.duty_ticks);
    assign measure_cmp = TIMER_BITS'(cfg.measure_ticks);
    assign timer_inc   = cycle_timer_reg + TIMER_BITS'(1);
    assign cycle_end   = (timer_inc == measure_cmp);
    assign count_sat   = (pump_count_reg == COUNT_MAX) ? pump_count_reg
                                                       : pump_count_reg + COUNT_W'(1);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: begin
                if (cfg.enable && period_start) phase_next = PH_WAIT;
            end
            PH_WAIT: begin
                if (compare_ready) phase_next = feedback_high ? PH_IDLE : PH_PUMP;
            end
            PH_PUMP: begin
                if (cycle_end) phase_next = (count_sat < cfg.max_pumps) ? PH_WAIT : PH_MEAS;
            end
            PH_MEAS: begin
                if (adc_valid) phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // counters, stored sample and adc start pulse
    always_comb begin
        pump_count_next     = pump_count_reg;
        cycle_timer_next    = cycle_timer_reg;
        battery_sample_next = battery_sample_reg;
        adc_start           = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (cfg.enable && period_start) pump_count_next = '0;
            end
            PH_WAIT: begin
                if (compare_ready && !feedback_high) cycle_timer_next = '0;
            end
            PH_PUMP: begin
                cycle_timer_next = timer_inc;
                if (cycle_end) begin
                    pump_count_next = count_sat;
                    adc_start       = !(count_sat < cfg.max_pumps);
                end
            end
            PH_MEAS: begin
                if (adc_valid) battery_sample_next = adc_sample;
            end
            default: begin
                pump_count_next = pump_count_reg;
            end
        endcase
    end

    // battery level: sample * 2 / 17 by reciprocal multiply
    assign sample_dbl = {battery_sample_next, 1'b0};
    assign level_prod = PROD_W'(sample_dbl) * PROD_W'(DIV17_MUL);

    // result fields after this tick's update
    always_comb begin
        result.pump_on       = (phase_next == PH_PUMP) && (cycle_timer_next < duty_cmp);
        result.adc_start     = adc_start;
        result.phase         = phase_next;
        result.pumps_done    = pump_count_next;
        result.battery_level = level_prod[DIV17_SHIFT +: LEVEL_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            pump_count_reg     <= '0;
            cycle_timer_reg    <= '0;
            battery_sample_reg <= '0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            pump_count_reg     <= pump_count_next;
            cycle_timer_reg    <= cycle_timer_next;
            battery_sample_reg <= battery_sample_next;
        end
    end

    // a measurement request only ends a pump cycle
    `HVPBS_ASSERT(a_adc_start_from_pump, aclk, aresetn, !adc_start || (phase_reg == PH_PUMP && cycle_end), "adc start outside the end of a pump cycle")

    // a burst start leaves a cleared pump count
    `HVPBS_ASSERT_NEXT(a_burst_clears_count, aclk, aresetn, step_en && phase_reg == PH_IDLE && phase_next == PH_WAIT, pump_count_reg == '0, "pump count not cleared at burst start")

    // state holds while no tick is stepped
    `HVPBS_ASSERT_NEXT(a_hold_without_step, aclk, aresetn, !step_en, $stable(phase_reg) && $stable(pump_count_reg) && $stable(cycle_timer_reg), "sequencer state moved without a tick")

endmodule

`default_nettype wire

>>> hw/rtl/hv_pump_burst_sequencer.sv
// top level of the high-voltage pump burst sequencer
//
// Each request on the slave stream is one timebase tick and yields exactly one
// result on the master stream. A new tick is taken every clock cycle as long as
// the master side keeps up; a result reaches the master stream once its tick,
// held in the input register, has passed the single-pass state update into the
// result register. Only m_tready backpressure slows the flow: while a finished
// result waits in the output register, the input register takes at most one
// more tick and s_tready then stays low until the result is taken.
// Configuration writes apply at once and are meant to be issued while the
// sequencer is idle and no tick is in flight.
`default_nettype none

module hv_pump_burst_sequencer
    import hvpbs_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int ADC_BITS   = 10,
    localparam int IN_BITS   = 4 + ADC_BITS,
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // tick stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // period_start, compare_ready, feedback_high, adc_valid, adc_sample
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pump_on, adc_start, phase, pumps_done, battery_level
    output logic [M_TDATA_W-1:0]       m_tdata
);

    hvpbs_cfg_t          cfg;
    hvpbs_result_t       result;

    logic                in_valid_reg, in_valid_next;
    logic [IN_BITS-1:0]  in_data_reg;
    logic                m_valid_reg, m_valid_next;
    hvpbs_result_t       m_data_reg;
    logic                out_free;
    logic                step_go;

    // handshake between input register and result register
    assign out_free      = !m_valid_reg || m_tready;
    assign step_go       = in_valid_reg && out_free;
    assign s_tready      = !in_valid_reg || out_free;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !step_go);
    assign m_valid_next  = step_go || (m_valid_reg && !m_tready);

    hvpbs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hvpbs_seq #(
        .TIMER_BITS (TIMER_BITS),
        .ADC_BITS   (ADC_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_go),
        .period_start  (in_data_reg[0]),
        .compare_ready (in_data_reg[1]),
        .feedback_high (in_data_reg[2]),
        .adc_valid     (in_data_reg[3]),
        .adc_sample    (in_data_reg[4 +: ADC_BITS]),
        .cfg           (cfg),
        .result        (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_BITS)'(0), m_data_reg};

endmodule

`default_nettype wire
